// ===== src/bept_pkg.sv =====
// Shared types, constants and helpers of the blob extreme-point tracker.
package bept_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int SIZE_W      = 12;
	localparam int COORD_W     = 11;
	localparam int PIXEL_W     = 8;
	localparam int NUM_CORNERS = 8;
	localparam int CORNER_W    = 3;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PIXEL_W-1:0] FG_VALUE = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CORNER_W-1:0] CORNER_LEFT_LAST    = 3'd0;
	localparam logic [CORNER_W-1:0] CORNER_LEFT_FIRST   = 3'd1;
	localparam logic [CORNER_W-1:0] CORNER_TOP_FIRST    = 3'd2;
	localparam logic [CORNER_W-1:0] CORNER_TOP_LAST     = 3'd3;
	localparam logic [CORNER_W-1:0] CORNER_RIGHT_FIRST  = 3'd4;
	localparam logic [CORNER_W-1:0] CORNER_RIGHT_LAST   = 3'd5;
	localparam logic [CORNER_W-1:0] CORNER_BOTTOM_LAST  = 3'd6;
	localparam logic [CORNER_W-1:0] CORNER_BOTTOM_FIRST = 3'd7;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} bept_point_t;

	typedef bept_point_t [NUM_CORNERS-1:0] bept_points_t;

	// Frame report handed from the tracker to the report buffer.
	typedef struct packed {
		logic         done;
		logic         found;
		bept_points_t points;
	} bept_frame_t;

	// A size of zero acts as one, a size above the maximum acts as the maximum.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = {{(SIZE_W-1){1'b0}}, 1'b1};
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== src/bept_tracker.sv =====
// Column/row counters and the eight extreme-point registers of the tracker.
module bept_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [bept_pkg::PIXEL_W-1:0]  pixel,
	input  logic [bept_pkg::SIZE_W-1:0]   eff_width,
	input  logic [bept_pkg::SIZE_W-1:0]   eff_height,
	input  logic                          sink_free,
	output logic                          item_take,
	output bept_pkg::bept_frame_t         frame
);
	import bept_pkg::*;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               any_q;
	bept_points_t       pts_q;
	bept_points_t       pts_d;
	logic               fg;
	logic               first;
	logic               row_end;
	logic               frame_end;
	bept_point_t        cur;

	assign fg        = (pixel == FG_VALUE);
	assign first     = !any_q;
	assign cur.x     = col_q;
	assign cur.y     = row_q;
	assign row_end   = ({1'b0, col_q} + 12'd1) >= eff_width;
	assign frame_end = row_end && (({1'b0, row_q} + 12'd1) >= eff_height);

	// The last pixel of a frame can only move on when the report buffer takes it.
	assign item_take = item_valid && (!frame_end || sink_free);

	// Eight parallel compares; "first" points need a strict improvement.
	always_comb begin
		pts_d = pts_q;
		if (fg) begin
			if (first || pts_q[CORNER_LEFT_FIRST].x > col_q) pts_d[CORNER_LEFT_FIRST] = cur;
			if (first || pts_q[CORNER_LEFT_LAST].x >= col_q) pts_d[CORNER_LEFT_LAST] = cur;
			if (first || pts_q[CORNER_TOP_FIRST].y > row_q) pts_d[CORNER_TOP_FIRST] = cur;
			if (first || pts_q[CORNER_TOP_LAST].y >= row_q) pts_d[CORNER_TOP_LAST] = cur;
			if (pts_q[CORNER_RIGHT_FIRST].x < col_q) pts_d[CORNER_RIGHT_FIRST] = cur;
			if (pts_q[CORNER_RIGHT_LAST].x <= col_q) pts_d[CORNER_RIGHT_LAST] = cur;
			if (pts_q[CORNER_BOTTOM_FIRST].y < row_q) pts_d[CORNER_BOTTOM_FIRST] = cur;
			if (pts_q[CORNER_BOTTOM_LAST].y <= row_q) pts_d[CORNER_BOTTOM_LAST] = cur;
		end
	end

	assign frame.done   = item_take && frame_end;
	assign frame.found  = any_q || fg;
	assign frame.points = pts_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			any_q <= 1'b0;
			pts_q <= '0;
		end else if (item_take) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				any_q <= 1'b0;
				pts_q <= '0;
			end else begin
				any_q <= any_q || fg;
				pts_q <= pts_d;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 11'd1;
				end else begin
					col_q <= col_q + 11'd1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> (col_q == '0) && (row_q == '0) && !any_q)
		else $error("tracker state not cleared after frame end");
`endif

endmodule

// ===== src/bept_report.sv =====
// Report buffer that holds one frame's eight points and hands them out in order.
module bept_report (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bept_pkg::bept_frame_t             frame,
	output logic                              free,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bept_pkg::CORNER_W-1:0]     corner_index,
	output logic [bept_pkg::COORD_W-1:0]      corner_x,
	output logic [bept_pkg::COORD_W-1:0]      corner_y,
	output logic                              found,
	output logic                              last_corner
);
	import bept_pkg::*;

	logic                valid_q;
	logic [CORNER_W-1:0] idx_q;
	logic                found_q;
	bept_points_t        pts_q;
	logic                take;
	logic                is_last;
	bept_point_t         sel;

	assign is_last = (idx_q == CORNER_BOTTOM_FIRST);
	assign take    = valid_q && out_ready;
	assign free    = !valid_q || (take && is_last);
	assign sel     = pts_q[idx_q];

	assign out_valid    = valid_q;
	assign corner_index = idx_q;
	assign corner_x     = found_q ? sel.x : '0;
	assign corner_y     = found_q ? sel.y : '0;
	assign found        = found_q;
	assign last_corner  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (frame.done) begin
			valid_q <= 1'b1;
			idx_q   <= CORNER_LEFT_LAST;
		end else if (take) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			found_q <= frame.found;
			pts_q   <= frame.points;
		end
	end

`ifndef SYNTHESIS
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !is_last |=> valid_q && (idx_q == $past(idx_q) + 3'd1))
		else $error("report skipped or dropped a corner");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(idx_q) && $stable(found_q))
		else $error("report changed while stalled");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |-> free)
		else $error("frame report loaded over an unfinished one");
`endif

endmodule

// ===== src/blob_extreme_point_tracker_core.sv =====
// Top level of the blob extreme-point tracker: config registers, input stage, tracker, report.
//
//  Channel   Direction  Handshake            Payload
//  in        request in in_valid/in_ready   pixel
//  out       result out out_valid/out_ready corner_index, corner_x, corner_y, found, last_corner
//  cfg       write      cfg_we               cfg_index, cfg_data
//
// One pixel is taken every cycle unless the input stalls; it waits in the input register
// and is then folded into the eight extreme-point registers, so throughput is one pixel/clock.
// At the last pixel of a frame the points are copied into the report buffer, which hands
// out its eight results one at a time while the next frame keeps streaming.
// Input stalls only when a frame ends before the previous report has drained (frames of
// fewer than eight pixels, or a stalled output side).
// Reset (arst_n low) restores a 640 x 480 frame size and empties every stage.
module blob_extreme_point_tracker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bept_pkg::PIXEL_W-1:0]      pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bept_pkg::CORNER_W-1:0]     corner_index,
	output logic [bept_pkg::COORD_W-1:0]      corner_x,
	output logic [bept_pkg::COORD_W-1:0]      corner_y,
	output logic                              found,
	output logic                              last_corner,
	input  logic                              cfg_we,
	input  logic [bept_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bept_pkg::SIZE_W-1:0]       cfg_data
);
	import bept_pkg::*;

	logic [SIZE_W-1:0]  frame_width_q;
	logic [SIZE_W-1:0]  frame_height_q;
	logic [SIZE_W-1:0]  eff_width;
	logic [SIZE_W-1:0]  eff_height;
	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic               item_take;
	logic               report_free;
	bept_frame_t        frame;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Out-of-range sizes are clamped into the supported range.
	assign eff_width  = eff_size(frame_width_q, SIZE_W'(MAX_WIDTH));
	assign eff_height = eff_size(frame_height_q, SIZE_W'(MAX_HEIGHT));

	// The input register refills in the same cycle it hands its pixel on.
	assign in_ready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1 <= pixel;
		end
	end

	bept_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.pixel      (pixel_s1),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.sink_free  (report_free),
		.item_take  (item_take),
		.frame      (frame)
	);

	bept_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.free         (report_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.corner_index (corner_index),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.found        (found),
		.last_corner  (last_corner)
	);

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_take |=> valid_s1 && $stable(pixel_s1))
		else $error("input register lost a waiting pixel");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> valid_s1)
		else $error("tracker consumed an empty input register");
`endif

endmodule
